>>> design/gsc_pkg.sv
// ----------------------------------------------------------------------------
// gsc_pkg
// Shared widths, register indexes and reset values for the gamepad sample
// conditioner.
// ----------------------------------------------------------------------------
package gsc_pkg;

    localparam int AXIS_W  = 16;
    localparam int Q15_W   = 15;
    localparam int TRIG_W  = 8;
    localparam int BTN_W   = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int BUTTON_COUNT_DEF = 14;

    localparam logic [CFG_IDX_W-1:0] REG_DEAD_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_THR  = 2'd2;

    localparam logic [Q15_W-1:0]  DEAD_LOW_RST  = 15'd8689;
    localparam logic [Q15_W-1:0]  DEAD_HIGH_RST = 15'd31129;
    localparam logic [TRIG_W-1:0] TRIG_THR_RST  = 8'd30;

    localparam logic [Q15_W-1:0] FULL_Q15 = 15'd32767;

    typedef struct packed {
        logic start;
        logic busy;
    } lane_ctl_t;

endpackage

>>> design/gsc_divider.sv
// ----------------------------------------------------------------------------
// gsc_divider
// Restoring divider, one quotient bit per cycle, 32-bit dividend and
// 16-bit divisor, 32-bit quotient.
// ----------------------------------------------------------------------------
module gsc_divider
    import gsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [31:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] dvs_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;
    logic [17:0] diff;

    always_comb
    begin
        trial     = {rem_reg[15:0], quo_reg[31]};
        diff      = {1'b0, trial} - {2'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[17])
            begin
                rem_next = diff[16:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
            dvs_reg <= divisor;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> design/gsc_stick_lane.sv
// ----------------------------------------------------------------------------
// gsc_stick_lane
// One stick: saturate, radius by bit-pair square root, dead-zone remap and
// rescale of both components through one shared serial divider.
// ----------------------------------------------------------------------------
module gsc_stick_lane
    import gsc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [AXIS_W-1:0] ax,
    input  logic signed [AXIS_W-1:0] ay,
    input  logic [Q15_W-1:0]         dead_low,
    input  logic [Q15_W-1:0]         dead_high,
    output logic                     done,
    output logic [AXIS_W-1:0]        ox,
    output logic [AXIS_W-1:0]        oy
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_SQRT = 3'd2;
    localparam logic [2:0] S_MAP  = 3'd3;
    localparam logic [2:0] S_DIVC = 3'd4;
    localparam logic [2:0] S_DIVX = 3'd5;
    localparam logic [2:0] S_DIVY = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]  state_reg;
    logic [15:0] mx_reg, my_reg;
    logic        sx_reg, sy_reg;
    logic [15:0] res_reg;
    logic [3:0]  it_reg;
    logic [15:0] c_reg;
    logic [15:0] ox_reg, oy_reg;
    logic        done_reg;

    logic [15:0] mx_in, my_in;
    logic [31:0] sq_x, sq_y;
    logic [31:0] sq_sum;
    logic [17:0] trial;

    logic        div_start;
    logic [31:0] div_dividend;
    logic [15:0] div_divisor;
    logic        div_done;
    logic [31:0] div_q;
    logic [15:0] qsat;

    function automatic logic [15:0] mag_of(input logic signed [15:0] v);
        logic [15:0] m;
        if (v[15])
            m = 16'(-v);
        else
            m = v;
        if (m > 16'd32767)
            m = 16'd32767;
        return m;
    endfunction

    assign mx_in = mag_of(ax);
    assign my_in = mag_of(ay);
    assign sq_x  = mx_reg * mx_reg;
    assign sq_y  = my_reg * my_reg;
    assign sq_sum = sq_x + sq_y;

    assign trial  = {res_reg, 2'b01};

    assign qsat     = (div_q > 32'd32767) ? 16'd32767 : div_q[15:0];

    // radix-4 square root, radicand bit pairs taken from its upper bits
    logic [31:0] rad_reg;
    logic [17:0] rem_reg;
    logic [19:0] rtry;
    logic [19:0] rsub;
    assign rtry = {rem_reg, rad_reg[31:30]};
    assign rsub = rtry - {2'b0, trial};

    // S_DIVX is entered either with a division already launched from S_DIVC,
    // or straight from S_MAP at full radius, which launches the x division.
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = res_reg;
        if (state_reg == S_MAP)
        begin
            if (res_reg > {1'b0, dead_low} && res_reg < {1'b0, dead_high})
            begin
                div_start    = 1'b1;
                div_dividend = 32'(res_reg - {1'b0, dead_low}) * 32'd32767;
                div_divisor  = 16'(dead_high - dead_low);
            end
            else if (res_reg > {1'b0, dead_low})
            begin
                div_start    = 1'b1;
                div_dividend = 32'(mx_reg) * 32'(FULL_Q15) + 32'(res_reg[15:1]);
            end
        end
        else if (state_reg == S_DIVC && div_done && div_q[15:0] != 16'd0)
        begin
            div_start    = 1'b1;
            div_dividend = 32'(mx_reg) * 32'(div_q[15:0]) + 32'(res_reg[15:1]);
        end
        else if (state_reg == S_DIVX && div_done)
        begin
            div_start    = 1'b1;
            div_dividend = 32'(my_reg) * 32'(c_reg) + 32'(res_reg[15:1]);
        end
    end

    gsc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                        state_reg <= S_SQ;
                end
                S_SQ:
                    state_reg <= S_SQRT;
                S_SQRT:
                begin
                    if (it_reg == 4'd15)
                        state_reg <= S_MAP;
                end
                S_MAP:
                begin
                    if (res_reg == 16'd0 || res_reg <= {1'b0, dead_low})
                        state_reg <= S_DONE;
                    else if (res_reg >= {1'b0, dead_high})
                        state_reg <= S_DIVX;
                    else
                        state_reg <= S_DIVC;
                end
                S_DIVC:
                begin
                    if (div_done)
                        state_reg <= (div_q[15:0] == 16'd0) ? S_DONE : S_DIVX;
                end
                S_DIVX:
                begin
                    if (div_done)
                        state_reg <= S_DIVY;
                end
                S_DIVY:
                begin
                    if (div_done)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mx_reg <= mx_in;
                    my_reg <= my_in;
                    sx_reg <= ax[15];
                    sy_reg <= ay[15];
                    ox_reg <= '0;
                    oy_reg <= '0;
                    c_reg  <= '0;
                end
            end
            S_SQ:
            begin
                rad_reg <= sq_sum;
                rem_reg <= '0;
                res_reg <= '0;
                it_reg  <= '0;
            end
            S_SQRT:
            begin
                rad_reg <= {rad_reg[29:0], 2'b00};
                it_reg  <= it_reg + 4'd1;
                if (!rsub[19])
                begin
                    rem_reg <= rsub[17:0];
                    res_reg <= {res_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rtry[17:0];
                    res_reg <= {res_reg[14:0], 1'b0};
                end
            end
            S_MAP:
            begin
                if (res_reg >= {1'b0, dead_high} && res_reg > {1'b0, dead_low})
                    c_reg <= 16'd32767;
            end
            S_DIVC:
            begin
                if (div_done)
                    c_reg <= div_q[15:0];
            end
            S_DIVX:
            begin
                if (div_done)
                    ox_reg <= sx_reg ? 16'(-qsat) : qsat;
            end
            S_DIVY:
            begin
                if (div_done)
                    oy_reg <= sy_reg ? 16'(-qsat) : qsat;
            end
            default:
            begin
            end
        endcase
    end

    assign done = done_reg;
    assign ox   = ox_reg;
    assign oy   = oy_reg;

endmodule

>>> design/gsc_trigger_lane.sv
// ----------------------------------------------------------------------------
// gsc_trigger_lane
// One trigger: threshold, offset and rounded division over the span.
// ----------------------------------------------------------------------------
module gsc_trigger_lane
    import gsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TRIG_W-1:0] raw,
    input  logic [TRIG_W-1:0] thr,
    output logic              done,
    output logic [Q15_W-1:0]  val
);

    logic        zero_reg;
    logic        wait_reg;
    logic        done_reg;
    logic [Q15_W-1:0] val_reg;
    logic [7:0]  span;
    logic [31:0] num;
    logic        div_done;
    logic [31:0] div_q;
    logic        go;

    assign span = 8'd255 - thr;
    assign num  = 32'(raw - thr) * 32'd32767 + 32'(span[7:1]);
    assign go   = start && (raw > thr);

    gsc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (go),
        .dividend (num),
        .divisor  ({8'd0, span}),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (start && !go) || (wait_reg && div_done);
            if (go)
                wait_reg <= 1'b1;
            else if (div_done)
                wait_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !go)
            val_reg <= '0;
        else if (wait_reg && div_done)
            val_reg <= div_q[Q15_W-1:0];
    end

    assign zero_reg = 1'b0;
    assign done = done_reg | zero_reg;
    assign val  = val_reg;

endmodule

>>> design/gamepad_sample_conditioner_top.sv
// ----------------------------------------------------------------------------
// gamepad_sample_conditioner_top
// Conditions one gamepad poll: radial dead zone on both sticks, trigger
// thresholds and button edge masks.
//
// channel  signals                          direction
// in       in_valid / in_ready + fields     to block
// out      out_valid / out_ready + fields   from block
// cfg      cfg_valid / cfg_ready, idx, data to block
//
// Stick lanes and trigger lanes run side by side. A stick lane squares, takes
// the square root, then runs up to three serial divisions (two at full radius,
// none in the dead zone); out_valid rises once all four lanes are done. Polls
// not present pass through pend_reg to out_valid. One transaction at a time;
// input ready again the cycle after the result is taken, unless config waits.
// Config taken only between polls, ahead of input. Reset async, low.
// ----------------------------------------------------------------------------
module gamepad_sample_conditioner_top
    import gsc_pkg::*;
#(
    parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     present,
    input  logic signed [AXIS_W-1:0] left_x,
    input  logic signed [AXIS_W-1:0] left_y,
    input  logic signed [AXIS_W-1:0] right_x,
    input  logic signed [AXIS_W-1:0] right_y,
    input  logic [TRIG_W-1:0]        left_trigger,
    input  logic [TRIG_W-1:0]        right_trigger,
    input  logic [BTN_W-1:0]         buttons,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     connected,
    output logic signed [AXIS_W-1:0] left_x_out,
    output logic signed [AXIS_W-1:0] left_y_out,
    output logic signed [AXIS_W-1:0] right_x_out,
    output logic signed [AXIS_W-1:0] right_y_out,
    output logic [Q15_W-1:0]         left_trig_out,
    output logic [Q15_W-1:0]         right_trig_out,
    output logic [BTN_W-1:0]         buttons_down,
    output logic [BTN_W-1:0]         buttons_changed,
    output logic [BTN_W-1:0]         buttons_pressed,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    localparam logic [BTN_W-1:0] BTN_MASK = BTN_W'((17'd1 << BUTTON_COUNT) - 17'd1);

    logic [Q15_W-1:0]  dead_low_reg, dead_high_reg;
    logic [TRIG_W-1:0] thr_reg;
    logic              busy_reg;
    logic              pend_reg;
    logic              out_valid_reg;
    logic              conn_reg;
    logic [3:0]        got_reg;
    logic [BTN_W-1:0]  btn_held_reg, btn_chg_reg, btn_new_reg;
    logic [AXIS_W-1:0] lx_reg, ly_reg, rx_reg, ry_reg;
    logic [Q15_W-1:0]  lt_reg, rt_reg;
    lane_ctl_t         ctl;

    logic              accept;
    logic              d_ls, d_rs, d_lt, d_rt;
    logic [AXIS_W-1:0] ls_x, ls_y, rs_x, rs_y;
    logic [Q15_W-1:0]  lt_v, rt_v;
    logic [3:0]        got_now;

    assign in_ready  = !busy_reg && !pend_reg && !out_valid_reg && !cfg_valid;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = !busy_reg && !pend_reg;
    assign ctl.start = accept && present;
    assign ctl.busy  = busy_reg;

    gsc_stick_lane u_ls (.clk(clk), .rst_n(rst_n), .start(ctl.start), .ax(left_x),
        .ay(left_y), .dead_low(dead_low_reg), .dead_high(dead_high_reg),
        .done(d_ls), .ox(ls_x), .oy(ls_y));
    gsc_stick_lane u_rs (.clk(clk), .rst_n(rst_n), .start(ctl.start), .ax(right_x),
        .ay(right_y), .dead_low(dead_low_reg), .dead_high(dead_high_reg),
        .done(d_rs), .ox(rs_x), .oy(rs_y));
    gsc_trigger_lane u_lt (.clk(clk), .rst_n(rst_n), .start(ctl.start),
        .raw(left_trigger), .thr(thr_reg), .done(d_lt), .val(lt_v));
    gsc_trigger_lane u_rt (.clk(clk), .rst_n(rst_n), .start(ctl.start),
        .raw(right_trigger), .thr(thr_reg), .done(d_rt), .val(rt_v));

    assign got_now = got_reg | {d_rt, d_lt, d_rs, d_ls};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_low_reg  <= DEAD_LOW_RST;
            dead_high_reg <= DEAD_HIGH_RST;
            thr_reg       <= TRIG_THR_RST;
            busy_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            conn_reg      <= 1'b0;
            got_reg       <= '0;
            btn_held_reg  <= '0;
            btn_chg_reg   <= '0;
            lx_reg        <= '0;
            ly_reg        <= '0;
            rx_reg        <= '0;
            ry_reg        <= '0;
            lt_reg        <= '0;
            rt_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_DEAD_LOW:  dead_low_reg  <= cfg_data[Q15_W-1:0];
                    REG_DEAD_HIGH: dead_high_reg <= cfg_data[Q15_W-1:0];
                    REG_TRIG_THR:  thr_reg       <= cfg_data[TRIG_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (accept)
            begin
                conn_reg <= present;
                if (present)
                begin
                    busy_reg     <= 1'b1;
                    got_reg      <= '0;
                    btn_chg_reg  <= (buttons & BTN_MASK) ^ btn_held_reg;
                    btn_held_reg <= buttons & BTN_MASK;
                end
                else
                    pend_reg <= 1'b1;
            end
            if (pend_reg)
            begin
                pend_reg      <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            if (busy_reg)
            begin
                got_reg <= got_now;
                if (d_ls)
                begin
                    lx_reg <= ls_x;
                    ly_reg <= ls_y;
                end
                if (d_rs)
                begin
                    rx_reg <= rs_x;
                    ry_reg <= rs_y;
                end
                if (d_lt)
                    lt_reg <= lt_v;
                if (d_rt)
                    rt_reg <= rt_v;
                if (got_now == 4'hF)
                begin
                    busy_reg      <= 1'b0;
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    assign btn_new_reg     = btn_held_reg & btn_chg_reg;
    assign out_valid       = out_valid_reg;
    assign connected       = conn_reg;
    assign left_x_out      = lx_reg;
    assign left_y_out      = ly_reg;
    assign right_x_out     = rx_reg;
    assign right_y_out     = ry_reg;
    assign left_trig_out   = lt_reg;
    assign right_trig_out  = rt_reg;
    assign buttons_down    = btn_held_reg;
    assign buttons_changed = btn_chg_reg;
    assign buttons_pressed = btn_new_reg;

endmodule

>>> design/gsc_checker.sv
// ----------------------------------------------------------------------------
// gsc_checker
// Port-level checks on the conditioner.
// ----------------------------------------------------------------------------
module gsc_checker
    import gsc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [BTN_W-1:0] buttons_down,
    input logic [BTN_W-1:0] buttons_changed,
    input logic [BTN_W-1:0] buttons_pressed
);

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result waits");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(buttons_down))
        else $error("result dropped while stalled");

    a_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        buttons_pressed == (buttons_down & buttons_changed))
        else $error("pressed mask wrong");

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction accepted while working");

endmodule

bind gamepad_sample_conditioner_top gsc_checker u_gsc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .buttons_down    (buttons_down),
    .buttons_changed (buttons_changed),
    .buttons_pressed (buttons_pressed)
);

>>> tb/gamepad_sample_conditioner_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gamepad_sample_conditioner_top_tb
// Drives polls through the conditioner and compares every result against an
// in-bench model of the radial dead zone, trigger mapping and button masks.
// Directed rows first, then random polls under several register settings.
// ----------------------------------------------------------------------------
module gamepad_sample_conditioner_top_tb;
    import gsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 300;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic                     present;
        logic signed [AXIS_W-1:0] lx;
        logic signed [AXIS_W-1:0] ly;
        logic signed [AXIS_W-1:0] rx;
        logic signed [AXIS_W-1:0] ry;
        logic [TRIG_W-1:0]        lt;
        logic [TRIG_W-1:0]        rt;
        logic [BTN_W-1:0]         btn;
    } poll_t;

    typedef struct packed {
        logic                     conn;
        logic signed [AXIS_W-1:0] lx;
        logic signed [AXIS_W-1:0] ly;
        logic signed [AXIS_W-1:0] rx;
        logic signed [AXIS_W-1:0] ry;
        logic [Q15_W-1:0]         lt;
        logic [Q15_W-1:0]         rt;
        logic [BTN_W-1:0]         down;
        logic [BTN_W-1:0]         chg;
        logic [BTN_W-1:0]         press;
    } cond_t;

    typedef struct packed {
        poll_t p;
        logic  typed;
        cond_t r;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    poll_t drv = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    cond_t got;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state
    int unsigned m_dlow, m_dhigh, m_thr;
    logic [BTN_W-1:0] m_btn, m_chg;
    logic [AXIS_W-1:0] m_stick [4];
    logic [Q15_W-1:0] m_trig [2];

    cond_t conditioned_q [$];
    int errors = 0;
    int idle_count = 0;
    bit rx_idle_en = 1'b1;
    bit tx_idle_en = 1'b1;
    bit hold_off = 1'b0;

    gamepad_sample_conditioner_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .present(drv.present), .left_x(drv.lx), .left_y(drv.ly),
        .right_x(drv.rx), .right_y(drv.ry),
        .left_trigger(drv.lt), .right_trigger(drv.rt), .buttons(drv.btn),
        .out_valid(out_valid), .out_ready(out_ready),
        .connected(got.conn), .left_x_out(got.lx), .left_y_out(got.ly),
        .right_x_out(got.rx), .right_y_out(got.ry),
        .left_trig_out(got.lt), .right_trig_out(got.rt),
        .buttons_down(got.down), .buttons_changed(got.chg),
        .buttons_pressed(got.press),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned lo, hi, mid;
        lo = 0;
        hi = 65536;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) / 2;
            if (mid * mid <= n)
                lo = mid;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic logic [AXIS_W-1:0] scale_axis(longint v, longint unsigned c,
                                                     longint unsigned r);
        longint unsigned mag, q;
        mag = (v < 0) ? -v : v;
        if (c == 0 || r == 0)
            return '0;
        q = (mag * c + r / 2) / r;
        if (q > 32767)
            q = 32767;
        return (v < 0) ? AXIS_W'(-longint'(q)) : AXIS_W'(q);
    endfunction

    function automatic void dead_zone(input logic signed [AXIS_W-1:0] ax,
                                      input logic signed [AXIS_W-1:0] ay,
                                      output logic [AXIS_W-1:0] ox,
                                      output logic [AXIS_W-1:0] oy);
        longint x, y;
        longint unsigned r, c;
        x = (ax == -32768) ? -32767 : ax;
        y = (ay == -32768) ? -32767 : ay;
        r = int_sqrt(x * x + y * y);
        if (r <= m_dlow)
            c = 0;
        else if (r >= m_dhigh)
            c = 32767;
        else
            c = (r - m_dlow) * 32767 / (m_dhigh - m_dlow);
        ox = scale_axis(x, c, r);
        oy = scale_axis(y, c, r);
    endfunction

    function automatic logic [Q15_W-1:0] trig_map(int unsigned t);
        int unsigned d;
        if (t <= m_thr)
            return '0;
        d = 255 - m_thr;
        return Q15_W'(((t - m_thr) * 32767 + d / 2) / d);
    endfunction

    function automatic cond_t condition_poll(poll_t p);
        cond_t r;
        if (p.present)
        begin
            dead_zone(p.lx, p.ly, m_stick[0], m_stick[1]);
            dead_zone(p.rx, p.ry, m_stick[2], m_stick[3]);
            m_trig[0] = trig_map(p.lt);
            m_trig[1] = trig_map(p.rt);
            m_chg = p.btn ^ m_btn;
            m_btn = p.btn;
        end
        r.conn = p.present;
        r.lx = m_stick[0];
        r.ly = m_stick[1];
        r.rx = m_stick[2];
        r.ry = m_stick[3];
        r.lt = m_trig[0];
        r.rt = m_trig[1];
        r.down = m_btn;
        r.chg = m_chg;
        r.press = m_btn & m_chg;
        return r;
    endfunction

    task automatic idle_burst(input bit en);
        if (en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    task automatic send_poll(input poll_t p, input bit typed, input cond_t want);
        cond_t pred;
        idle_burst(tx_idle_en);
        drv <= p;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pred = condition_poll(p);
        if (typed && pred !== want)
        begin
            $display("%0t: table row disagrees: expected %h actual %h", $time, want, pred);
            errors++;
        end
        conditioned_q.push_back(typed ? want : pred);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(val);
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_DEAD_LOW)
            m_dlow = val & 16'h7fff;
        else if (idx == REG_DEAD_HIGH)
            m_dhigh = val & 16'h7fff;
        else if (idx == REG_TRIG_THR)
            m_thr = val & 8'hff;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (conditioned_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    function automatic logic signed [AXIS_W-1:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return -32768;
            1: return 32767;
            2: return AXIS_W'($urandom_range(0, 4000)) - 16'sd2000;
            default: return AXIS_W'($urandom);
        endcase
    endfunction

    function automatic poll_t rand_poll();
        poll_t p;
        p.present = ($urandom_range(0, 7) != 0);
        p.lx = rand_axis();
        p.ly = rand_axis();
        p.rx = rand_axis();
        p.ry = rand_axis();
        p.lt = $urandom_range(0, 3) == 0 ? 8'hff : 8'($urandom);
        p.rt = $urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom);
        p.btn = $urandom_range(0, 1) ? (m_btn ^ BTN_W'(1 << $urandom_range(0, BTN_W - 1)))
                                     : BTN_W'($urandom);
        return p;
    endfunction

    // receiver: random stalls, one long hold-off, sampled at rising edge
    always @(negedge clk)
    begin
        if (hold_off)
            out_ready <= 1'b0;
        else if (rx_idle_en && $urandom_range(0, 3) == 0)
            out_ready <= 1'b0;
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (conditioned_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end
            else
            begin
                if (got !== conditioned_q[0])
                    $display("%0t: mismatch expected %h actual %h",
                             $time, conditioned_q[0], got);
                if (got !== conditioned_q[0])
                    errors++;
                void'(conditioned_q.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        row_t rows [$];
        cond_t z;
        poll_t p;
        int dl_set [4];
        int dh_set [4];
        int th_set [4];

        m_dlow = DEAD_LOW_RST;
        m_dhigh = DEAD_HIGH_RST;
        m_thr = TRIG_THR_RST;
        m_btn = '0;
        m_chg = '0;
        foreach (m_stick[i]) m_stick[i] = '0;
        foreach (m_trig[i]) m_trig[i] = '0;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        z = '0;
        // absent before any valid poll: all zero
        rows.push_back('{'{1'b0, 16'sd5000, -16'sd5000, 16'sd1, 16'sd1, 8'd200, 8'd9,
                           14'h3fff}, 1'b1, z});
        // centred, triggers at or below threshold, all buttons down
        rows.push_back('{'{1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd30, 8'd0, 14'h3fff},
                         1'b1, '{1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 15'd0, 15'd0,
                                 14'h3fff, 14'h3fff, 14'h3fff}});
        // full deflection on two axes, both triggers full, buttons released
        rows.push_back('{'{1'b1, 16'sd32767, 16'sd0, 16'sd0, -16'sd32768, 8'd255, 8'd255,
                           14'h0000}, 1'b1, '{1'b1, 16'sd32767, 16'sd0, 16'sd0,
                           -16'sd32767, 15'd32767, 15'd32767, 14'h0000, 14'h3fff, 14'h0000}});
        // held while absent
        rows.push_back('{'{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd0, 8'd0, 14'h1555},
                         1'b1, '{1'b0, 16'sd32767, 16'sd0, 16'sd0, -16'sd32767, 15'd32767,
                                 15'd32767, 14'h0000, 14'h3fff, 14'h0000}});
        rows.push_back('{'{1'b1, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 8'd31,
                           8'd254, 14'h1555}, 1'b0, z});
        rows.push_back('{'{1'b1, 16'sd8689, 16'sd0, 16'sd8690, 16'sd0, 8'd100, 8'd1,
                           14'h2aaa}, 1'b0, z});
        rows.push_back('{'{1'b1, 16'sd20000, -16'sd12000, -16'sd31128, 16'sd0, 8'd0, 8'd128,
                           14'h2aab}, 1'b0, z});
        rows.push_back('{'{1'b1, -16'sd1, 16'sd1, 16'sd31129, 16'sd1, 8'd29, 8'd255,
                           14'h0001}, 1'b0, z});
        foreach (rows[i])
            send_poll(rows[i].p, rows[i].typed, rows[i].r);
        drain();

        dl_set = '{0, 32767, 1000, 20000};
        dh_set = '{32767, 0, 1000, 20100};
        th_set = '{0, 254, 255, 128};
        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph > 0)
            begin
                write_reg(REG_DEAD_LOW, dl_set[ph - 1]);
                write_reg(REG_DEAD_HIGH, dh_set[ph - 1]);
                write_reg(REG_TRIG_THR, th_set[ph - 1]);
                write_reg(REG_SPARE, $urandom);
            end
            if (ph == 4)
            begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            for (int n = 0; n < 250; n++)
            begin
                if (ph == 1 && n == 20)
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (600) @(negedge clk);
                            hold_off = 1'b0;
                        end
                    join_none
                p = rand_poll();
                send_poll(p, 1'b0, z);
            end
            drain();
        end

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
